// ===== rtl/owsr_pkg.sv =====
// Package for the single-wire slave ROM command layer.
// Holds field widths, command codes, register indexes, shared types and the CRC helpers.
// No dependencies; every other file imports it.
package owsr_pkg;

    localparam int LOW_W   = 12;
    localparam int SP_W    = 8;
    localparam int CODE_W  = 56;
    localparam int ROM_W   = 64;
    localparam int BIT_W   = 6;
    localparam int CRC_W   = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CRC_W-1:0] CRC_POLY = 8'h8C;

    localparam logic [7:0] CMD_SEARCH   = 8'hF0;
    localparam logic [7:0] CMD_READ     = 8'h33;
    localparam logic [7:0] CMD_READ_ALT = 8'h0F;
    localparam logic [7:0] CMD_MATCH    = 8'h55;
    localparam logic [7:0] CMD_SKIP     = 8'hCC;
    localparam logic [7:0] CMD_RESUME   = 8'hA5;

    localparam logic [CFG_IDX_W-1:0] CFG_ROM_CODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_POINT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_MAX     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_MIN    = 2'd3;

    localparam logic [SP_W-1:0]  SAMPLE_POINT_RST = 8'd15;
    localparam logic [LOW_W-1:0] SLOT_MAX_RST     = 12'd120;
    localparam logic [LOW_W-1:0] RESET_MIN_RST    = 12'd470;

    localparam logic [BIT_W-1:0] CMD_LAST_BIT = 6'd7;
    localparam logic [BIT_W-1:0] ROM_LAST_BIT = 6'd63;

    typedef enum logic [1:0] {
        PK_SLOT,
        PK_RESET,
        PK_BAD
    } pulse_kind_t;

    typedef enum logic [1:0] {
        PH_CMD,
        PH_READ,
        PH_SEARCH,
        PH_MATCH
    } phase_t;

    typedef struct packed {
        pulse_kind_t kind;
        logic        mbit;
    } pulse_entry_t;

    typedef struct packed {
        logic [SP_W-1:0]  sample_point;
        logic [LOW_W-1:0] slot_max;
        logic [LOW_W-1:0] reset_min;
    } timing_cfg_t;

    typedef struct packed {
        logic presence;
        logic drive_zero_next;
        logic selected;
        logic dropped;
        logic bad_pulse;
    } result_t;

    typedef logic [CODE_W-1:0][CRC_W-1:0] crc_tbl_t;

    // CRC of a message with only bit pos set; the CRC is linear with zero init
    function automatic crc_tbl_t build_crc_tbl();
        crc_tbl_t        tbl;
        logic [CRC_W-1:0] crc;
        logic            mix;
        for (int pos = 0; pos < CODE_W; pos++)
        begin
            crc = '0;
            for (int i = 0; i < CODE_W; i++)
            begin
                mix = crc[0] ^ (i == pos);
                crc = crc >> 1;
                if (mix)
                begin
                    crc = crc ^ CRC_POLY;
                end
            end
            tbl[pos] = crc;
        end
        return tbl;
    endfunction

    localparam crc_tbl_t CRC_BIT_TBL = build_crc_tbl();

    function automatic logic [CRC_W-1:0] rom_crc(input logic [CODE_W-1:0] code);
        logic [CRC_W-1:0] crc;
        crc = '0;
        for (int i = 0; i < CODE_W; i++)
        begin
            if (code[i])
            begin
                crc = crc ^ CRC_BIT_TBL[i];
            end
        end
        return crc;
    endfunction

endpackage

// ===== rtl/owsr_if.sv =====
// Valid/ready channel interfaces for the ROM command layer.
// owsr_pulse_if carries measured low pulses, owsr_result_if carries results; uses owsr_pkg.
interface owsr_pulse_if
    import owsr_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [LOW_W-1:0] low_us;

    modport source (output valid, output low_us, input ready);
    modport sink   (input valid, input low_us, output ready);
endinterface

interface owsr_result_if;
    logic valid;
    logic ready;
    logic presence;
    logic drive_zero_next;
    logic selected;
    logic dropped;
    logic bad_pulse;

    modport source (output valid, output presence, output drive_zero_next,
                    output selected, output dropped, output bad_pulse, input ready);
    modport sink   (input valid, input presence, input drive_zero_next,
                    input selected, input dropped, input bad_pulse, output ready);
endinterface

// ===== rtl/owsr_front.sv =====
// Front end: classifies each pulse as reset, bad pulse or time slot and samples the master bit.
// Depends on owsr_pkg.
module owsr_front
    import owsr_pkg::*;
(
    input  logic             valid,
    input  logic [LOW_W-1:0] low_us,
    input  timing_cfg_t      cfg,
    input  logic             full,
    output logic             ready,
    output logic             push,
    output pulse_entry_t     entry
);

    always_comb
    begin
        priority if (low_us >= cfg.reset_min)
        begin
            entry.kind = PK_RESET;
        end
        else if (low_us > cfg.slot_max)
        begin
            entry.kind = PK_BAD;
        end
        else
        begin
            entry.kind = PK_SLOT;
        end
        entry.mbit = (low_us < {{(LOW_W-SP_W){1'b0}}, cfg.sample_point});
    end

    assign ready = !full;
    assign push  = valid && !full;

endmodule

// ===== rtl/owsr_queue.sv =====
// Two-entry queue between the classifier and the ROM sequencer.
// Depends on owsr_pkg.
module owsr_queue
    import owsr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  pulse_entry_t push_entry,
    input  logic         pop,
    output logic         full,
    output logic         not_empty,
    output pulse_entry_t head
);

    pulse_entry_t slot_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/owsr_back.sv =====
// Back end: ROM command sequencer (command byte, Read, Search, Match, Skip, Resume).
// Pops classified pulses and holds one result in an output register; depends on owsr_pkg.
module owsr_back
    import owsr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [ROM_W-1:0] rom,
    input  logic             q_valid,
    input  pulse_entry_t     q_head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output result_t          out_data
);

    logic             awaiting_reg, awaiting_next;
    logic             resume_reg, resume_next;
    phase_t           phase_reg, phase_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    logic [1:0]       sub_reg, sub_next;
    logic [7:0]       shift_reg, shift_next;
    logic             mfail_reg, mfail_next;
    logic             out_valid_reg;
    result_t          out_reg;
    result_t          res;

    logic       active_slot;
    logic       mismatch;
    logic       last_rom_bit;
    logic       cmd_done;
    logic [7:0] cmd_byte;
    logic       cmd_select;
    logic       cmd_drop;
    logic       bit_at_next;

    assign pop          = q_valid && (!out_valid_reg || out_ready);
    assign out_valid    = out_valid_reg;
    assign out_data     = out_reg;

    assign active_slot  = (q_head.kind == PK_SLOT) && !awaiting_reg;
    assign mismatch     = q_head.mbit != rom[bit_reg];
    assign last_rom_bit = (bit_reg >= ROM_LAST_BIT);
    assign cmd_done     = (bit_reg == CMD_LAST_BIT);
    assign cmd_byte     = {q_head.mbit, shift_reg[7:1]};
    assign cmd_select   = (cmd_byte == CMD_SKIP) || ((cmd_byte == CMD_RESUME) && resume_reg);
    assign cmd_drop     = !cmd_select && (cmd_byte != CMD_SEARCH) && (cmd_byte != CMD_READ)
                          && (cmd_byte != CMD_READ_ALT) && (cmd_byte != CMD_MATCH);
    assign bit_at_next  = rom[bit_next];

    always_comb
    begin
        awaiting_next = awaiting_reg;
        resume_next   = resume_reg;
        phase_next    = phase_reg;
        bit_next      = bit_reg;
        sub_next      = sub_reg;
        shift_next    = shift_reg;
        mfail_next    = mfail_reg;
        unique case (q_head.kind)
            PK_RESET:
            begin
                awaiting_next = 1'b0;
                phase_next    = PH_CMD;
                bit_next      = '0;
                sub_next      = '0;
                shift_next    = '0;
                mfail_next    = 1'b0;
            end
            PK_BAD:
            begin
                awaiting_next = 1'b1;
                phase_next    = PH_CMD;
                bit_next      = '0;
                sub_next      = '0;
                shift_next    = '0;
                mfail_next    = 1'b0;
            end
            PK_SLOT:
            begin
                if (!awaiting_reg)
                begin
                    unique case (phase_reg)
                        PH_CMD:
                        begin
                            shift_next = cmd_byte;
                            bit_next   = bit_reg + 6'd1;
                            if (cmd_done)
                            begin
                                bit_next   = '0;
                                shift_next = '0;
                                priority if (cmd_byte == CMD_SEARCH)
                                begin
                                    resume_next = 1'b0;
                                    phase_next  = PH_SEARCH;
                                end
                                else if (cmd_byte == CMD_READ || cmd_byte == CMD_READ_ALT)
                                begin
                                    phase_next = PH_READ;
                                end
                                else if (cmd_byte == CMD_MATCH)
                                begin
                                    phase_next = PH_MATCH;
                                end
                                else if (cmd_select)
                                begin
                                    resume_next = 1'b1;
                                end
                                else
                                begin
                                    resume_next   = 1'b0;
                                    awaiting_next = 1'b1;
                                end
                            end
                        end
                        PH_READ:
                        begin
                            if (last_rom_bit)
                            begin
                                phase_next = PH_CMD;
                                bit_next   = '0;
                            end
                            else
                            begin
                                bit_next = bit_reg + 6'd1;
                            end
                        end
                        PH_SEARCH:
                        begin
                            unique case (sub_reg)
                                2'd1:    sub_next = 2'd2;
                                2'd2:
                                begin
                                    if (mismatch || last_rom_bit)
                                    begin
                                        resume_next   = !mismatch;
                                        awaiting_next = mismatch;
                                        phase_next    = PH_CMD;
                                        bit_next      = '0;
                                        sub_next      = '0;
                                    end
                                    else
                                    begin
                                        bit_next = bit_reg + 6'd1;
                                        sub_next = 2'd0;
                                    end
                                end
                                default: sub_next = 2'd1;
                            endcase
                        end
                        PH_MATCH:
                        begin
                            if (last_rom_bit)
                            begin
                                resume_next   = !(mfail_reg || mismatch);
                                awaiting_next = mfail_reg || mismatch;
                                phase_next    = PH_CMD;
                                bit_next      = '0;
                                mfail_next    = 1'b0;
                            end
                            else
                            begin
                                mfail_next = mfail_reg || mismatch;
                                bit_next   = bit_reg + 6'd1;
                            end
                        end
                        default: phase_next = phase_reg;
                    endcase
                end
            end
            default: awaiting_next = awaiting_reg;
        endcase
    end

    always_comb
    begin
        res           = '0;
        res.presence  = (q_head.kind == PK_RESET);
        res.bad_pulse = (q_head.kind == PK_BAD);
        if (active_slot)
        begin
            unique case (phase_reg)
                PH_CMD:
                begin
                    res.selected = cmd_done && cmd_select;
                    res.dropped  = cmd_done && cmd_drop;
                end
                PH_SEARCH:
                begin
                    res.selected = (sub_reg == 2'd2) && !mismatch && last_rom_bit;
                    res.dropped  = (sub_reg == 2'd2) && mismatch;
                end
                PH_MATCH:
                begin
                    res.selected = last_rom_bit && !(mfail_reg || mismatch);
                    res.dropped  = last_rom_bit && (mfail_reg || mismatch);
                end
                default: res.selected = 1'b0;
            endcase
        end
        if (!awaiting_next)
        begin
            if (phase_next == PH_READ)
            begin
                res.drive_zero_next = !bit_at_next;
            end
            else if (phase_next == PH_SEARCH)
            begin
                if (sub_next == 2'd1)
                begin
                    res.drive_zero_next = bit_at_next;
                end
                else if (sub_next != 2'd2)
                begin
                    res.drive_zero_next = !bit_at_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg  <= 1'b1;
            resume_reg    <= 1'b0;
            phase_reg     <= PH_CMD;
            bit_reg       <= '0;
            sub_reg       <= '0;
            shift_reg     <= '0;
            mfail_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                awaiting_reg  <= awaiting_next;
                resume_reg    <= resume_next;
                phase_reg     <= phase_next;
                bit_reg       <= bit_next;
                sub_reg       <= sub_next;
                shift_reg     <= shift_next;
                mfail_reg     <= mfail_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= res;
        end
    end

endmodule

// ===== rtl/onewire_slave_rom_layer.sv =====
// Top level of the single-wire slave ROM command layer: register bank, classifier,
// queue and ROM sequencer. Depends on owsr_pkg, owsr_if, owsr_front, owsr_queue, owsr_back.
//
// Usage:
//   pulse  : valid/ready sink; one transfer per completed bus low pulse, low_us saturated.
//   result : valid/ready source; exactly one transfer per pulse, in order, carrying
//            presence, drive_zero_next, selected, dropped and bad_pulse.
//   cfg    : write port (cfg_we, cfg_index, cfg_data); 0 rom_code, 1 sample point,
//            2 slot maximum, 3 reset minimum. Write only while no pulse is in flight.
// Path: an accepted pulse is written into the queue, then popped into the result
// register once that register is free (empty or being read).
// Throughput: one pulse per cycle while result.ready is high, set by the sequencer step,
// which updates all ROM state per pop; the CRC byte is formed when rom_code is written.
// Reset: the block waits for a bus reset, resume flag clear, thresholds at defaults.
// When the result side stalls, the result register holds, the two-entry queue fills,
// and pulse.ready drops once it is full; nothing is lost.
module onewire_slave_rom_layer
    import owsr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    owsr_pulse_if.sink           pulse,
    owsr_result_if.source        result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CODE_W-1:0]    cfg_data
);

    timing_cfg_t      cfg_reg;
    logic [ROM_W-1:0] rom_reg;

    logic         full;
    logic         push;
    logic         pop;
    logic         not_empty;
    pulse_entry_t push_entry;
    pulse_entry_t head;
    result_t      res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_point <= SAMPLE_POINT_RST;
            cfg_reg.slot_max     <= SLOT_MAX_RST;
            cfg_reg.reset_min    <= RESET_MIN_RST;
            rom_reg              <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROM_CODE:     rom_reg <= {rom_crc(cfg_data), cfg_data};
                CFG_SAMPLE_POINT: cfg_reg.sample_point <= cfg_data[SP_W-1:0];
                CFG_SLOT_MAX:     cfg_reg.slot_max <= cfg_data[LOW_W-1:0];
                CFG_RESET_MIN:    cfg_reg.reset_min <= cfg_data[LOW_W-1:0];
                default:          rom_reg <= rom_reg;
            endcase
        end
    end

    owsr_front u_front
    (
        .valid  (pulse.valid),
        .low_us (pulse.low_us),
        .cfg    (cfg_reg),
        .full   (full),
        .ready  (pulse.ready),
        .push   (push),
        .entry  (push_entry)
    );

    owsr_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .not_empty  (not_empty),
        .head       (head)
    );

    owsr_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rom       (rom_reg),
        .q_valid   (not_empty),
        .q_head    (head),
        .pop       (pop),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (res)
    );

    assign result.presence        = res.presence;
    assign result.drive_zero_next = res.drive_zero_next;
    assign result.selected        = res.selected;
    assign result.dropped         = res.dropped;
    assign result.bad_pulse       = res.bad_pulse;

endmodule
